// ===== rtl/core/mbt_pkg.sv =====
// Shared types and constants for the Mandelbrot bounded-point test.
// Used by the divider, controller, datapath and top level; no dependencies.
package mbt_pkg;

  // Q8.24 fixed point for coordinates and z
  localparam int FRAC_BITS = 24;
  localparam int SAT_W     = 64;

  // register index field of the config port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

  // reset values of the registers
  localparam int X_RES_RST    = 512;
  localparam int Y_RES_RST    = 512;
  localparam int MAX_ITER_RST = 100;

  // 0.5 in Q8.24, and 0.7 in Q8.24
  localparam logic signed [SAT_W-1:0] HALF_Q  = 64'sd8388608;
  localparam logic signed [SAT_W-1:0] SEVEN_Q = 64'sd11744051;
  // offsets after 3*q: 3*0.5 for y, 3*0.5 + 0.7 for x
  localparam logic signed [SAT_W-1:0] OFS_Y = 64'sd25165824;
  localparam logic signed [SAT_W-1:0] OFS_X = 64'sd36909875;

  // escape threshold 100 in Q16.48
  localparam logic [SAT_W-1:0] ESCAPE_Q48 = 64'd100 << (2 * FRAC_BITS);

  localparam logic signed [SAT_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -64'sd2147483648;

  // controller -> datapath commands
  typedef struct packed {
    logic start;     // latch item, start the dividers, clear z
    logic map1;      // 3*quotient
    logic map2;      // subtract offsets and saturate into c
    logic mul;       // register x*x, y*y, x*y
    logic step;      // commit new z, bump iteration count
    logic finish;    // capture the bounded decision
    logic load_out;  // move decision into the output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
    logic escape;
    logic last;
  } status_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mbt_div.sv =====
// Restoring divider, one quotient bit per cycle: (idx << 24) / divisor.
// Depends on mbt_pkg for the fraction width.
module mbt_div import mbt_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       idx,
  input  logic [COORD_BITS-1:0]       divisor,
  output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
  output logic                        done
);

  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]         quo;
  logic [COORD_BITS-1:0] rem;
  logic [CW-1:0]         cnt;
  logic                  busy;

  logic [COORD_BITS:0]   trial;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[QW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {idx, {FRAC_BITS{1'b0}}};
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= COORD_BITS'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[COORD_BITS-1:0];
      end
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign quotient = quo;
  assign done     = ~busy;

endmodule

// ===== rtl/core/mbt_datapath.sv =====
// Datapath: config registers, coordinate dividers, c mapping, z iteration
// and output word register. Depends on mbt_pkg and mbt_div.
module mbt_datapath import mbt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  parameter int CFG_W      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  bounded
);

  localparam int QW = COORD_BITS + FRAC_BITS;

  logic [COORD_BITS-1:0] x_res;
  logic [COORD_BITS-1:0] y_res;
  logic [ITER_BITS-1:0]  max_iter;

  logic [COORD_BITS-1:0] x_div;
  logic [COORD_BITS-1:0] y_div;
  logic [QW-1:0]         qx;
  logic [QW-1:0]         qy;
  logic                  x_done;
  logic                  y_done;

  logic signed [SAT_W-1:0] tx3;
  logic signed [SAT_W-1:0] ty3;
  logic signed [SAT_W-1:0] qx_e;
  logic signed [SAT_W-1:0] qy_e;

  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] zx;
  logic signed [31:0] zy;
  logic signed [63:0] xx;
  logic signed [63:0] yy;
  logic signed [63:0] xy;
  logic [ITER_BITS-1:0] iter;
  logic result;

  logic signed [63:0] diff;
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  logic [63:0]        mag;

  // config registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      x_res    <= COORD_BITS'(X_RES_RST);
      y_res    <= COORD_BITS'(Y_RES_RST);
      max_iter <= ITER_BITS'(MAX_ITER_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_X_RES:    x_res    <= cfg_data[COORD_BITS-1:0];
        CFG_Y_RES:    y_res    <= cfg_data[COORD_BITS-1:0];
        CFG_MAX_ITER: max_iter <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a zero resolution divides as one
  assign x_div = (x_res == '0) ? COORD_BITS'(1) : x_res;
  assign y_div = (y_res == '0) ? COORD_BITS'(1) : y_res;

  mbt_div #(.COORD_BITS(COORD_BITS)) u_div_x (
    .clk(clk), .rst(rst), .start(cmd.start), .idx(column), .divisor(x_div),
    .quotient(qx), .done(x_done)
  );

  mbt_div #(.COORD_BITS(COORD_BITS)) u_div_y (
    .clk(clk), .rst(rst), .start(cmd.start), .idx(row), .divisor(y_div),
    .quotient(qy), .done(y_done)
  );

  // map quotient to c: 3*q, then subtract offsets and clamp
  assign qx_e = $signed({{(SAT_W-QW){1'b0}}, qx});
  assign qy_e = $signed({{(SAT_W-QW){1'b0}}, qy});

  always_ff @(posedge clk) begin
    if (cmd.map1) begin
      tx3 <= qx_e + (qx_e <<< 1);
      ty3 <= qy_e + (qy_e <<< 1);
    end
    if (cmd.map2) begin
      cx <= sat32(tx3 - OFS_X);
      cy <= sat32(ty3 - OFS_Y);
    end
  end

  // next z from registered products; shifts floor toward minus infinity
  assign diff = xx - yy;
  assign nx   = sat32((diff >>> FRAC_BITS) + $signed({{32{cx[31]}}, cx}));
  assign ny   = sat32((xy >>> (FRAC_BITS - 1)) + $signed({{32{cy[31]}}, cy}));
  assign mag  = $unsigned(xx) + $unsigned(yy);

  // z iteration registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      zx   <= '0;
      zy   <= '0;
      iter <= ITER_BITS'(1);
    end else if (cmd.step) begin
      zx   <= nx;
      zy   <= ny;
      iter <= iter + 1'b1;
    end
    if (cmd.mul) begin
      xx <= zx * zx;
      yy <= zy * zy;
      xy <= zx * zy;
    end
  end

  // decision and output word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= ~status.escape & (max_iter != '0);
    end
    if (cmd.load_out) begin
      bounded <= result;
    end
  end

  assign status.div_done = x_done & y_done;
  assign status.escape   = mag > ESCAPE_Q48;
  assign status.last     = iter >= max_iter;

endmodule

// ===== rtl/core/mbt_ctrl.sv =====
// Controller FSM: sequences division, mapping and the z loop, owns the
// handshakes. Depends on mbt_pkg for the command and status structs.
module mbt_ctrl import mbt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_MAP1 = 7'b0000100,
    S_MAP2 = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_MAP1;
        end
      end
      S_MAP1: begin
        cmd.map1   = 1'b1;
        state_next = S_MAP2;
      end
      S_MAP2: begin
        cmd.map2   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // check the previous z first, then either stop or step
        if (status.escape || status.last) begin
          cmd.finish = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

endmodule

// ===== rtl/core/mandelbrot_bounded_test.sv =====
// Mandelbrot bounded-point test: takes a pixel word (column, row), maps it
// to c in Q8.24 and runs z = z*z + c, returning one bounded bit per pixel.
// After a pixel is taken, the two parallel bit-serial dividers run at one
// quotient bit per cycle until both finish, mapping computes 3*q and then
// subtracts the offsets and clamps, each pass of the z loop is a product
// step on three 32x32 multipliers followed by an update and escape check,
// and a last step hands the word to the output register. The iteration
// counter starts at 1 and stops at the iteration limit or on escape. The
// next pixel is taken once the controller is back in its idle state. One
// pixel is in flight at a time; a finished pixel waits in its last state
// while the previous result is still held, and the output register lets
// a result wait while the next pixel is taken.
module mandelbrot_bounded_test import mbt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  localparam int CFG_W = (COORD_BITS > ITER_BITS) ? COORD_BITS : ITER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  bounded
);

  cmd_t    cmd;
  status_t status;

  mbt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  mbt_datapath #(
    .COORD_BITS(COORD_BITS), .ITER_BITS(ITER_BITS), .CFG_W(CFG_W)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .column(column), .row(row),
    .cmd(cmd), .status(status), .bounded(bounded)
  );

endmodule

// ===== rtl/core/mbt_checker.sv =====
// Port-level checks for the Mandelbrot bounded-point test, bound to the
// top level. Sees only the handshake ports and the result word.
module mbt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic bounded
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bounded))
    else $error("result word changed or dropped while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // one pixel at a time: accepting closes the input
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting a pixel");

  // a new result never appears in the cycle after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result raised right after an accept");

endmodule

bind mandelbrot_bounded_test mbt_checker u_mbt_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .bounded(bounded)
);
